>>> rtl/core/b3h_pkg.sv
package b3h_pkg;

   localparam int STACK_DEPTH = 54;
   localparam int STACK_AW    = 6;

   localparam logic [31:0] FLAG_START  = 32'd1;
   localparam logic [31:0] FLAG_END    = 32'd2;
   localparam logic [31:0] FLAG_PARENT = 32'd4;
   localparam logic [31:0] FLAG_ROOT   = 32'd8;

   // compression job kinds
   localparam logic [1:0] KIND_BLOCK   = 2'd0;
   localparam logic [1:0] KIND_PARENT  = 2'd1;
   localparam logic [1:0] KIND_FINAL   = 2'd2;
   localparam logic [1:0] KIND_FPARENT = 2'd3;

   localparam logic [4:0] LAST_STEP = 5'd27;   // 7 rounds x 4 quarter steps

   localparam logic [3:0] PERM [16] = '{
      4'd2, 4'd6, 4'd3, 4'd10, 4'd7, 4'd0, 4'd4, 4'd13,
      4'd1, 4'd11, 4'd12, 4'd5, 4'd9, 4'd14, 4'd15, 4'd8
   };

   typedef struct packed {
      logic [63:0] data_word;
      logic [3:0]  byte_count;
      logic        end_of_message;
   } b3h_req_type;

   typedef struct packed {
      logic [63:0] digest_word;
      logic        digest_last;
   } b3h_rsp_type;

   typedef struct packed {
      logic       take;
      logic       write;
      logic       load;
      logic       step;
      logic       finish;
      logic       pop;
      logic       push;
      logic       emit;
      logic [1:0] kind;
      logic [1:0] phase;
   } b3h_cmd_type;

   typedef struct packed {
      logic rem_zero;
      logic eom;
      logic buf_full;
      logic chunk_done;
      logic total_even;
      logic level_zero;
      logic out_busy;
   } b3h_status_type;

   function automatic logic [31:0] iv_word(input logic [2:0] idx);
      logic [31:0] w;
      unique case (idx)
         3'd0: w = 32'h6A09E667;
         3'd1: w = 32'hBB67AE85;
         3'd2: w = 32'h3C6EF372;
         3'd3: w = 32'hA54FF53A;
         3'd4: w = 32'h510E527F;
         3'd5: w = 32'h9B05688C;
         3'd6: w = 32'h1F83D9AB;
         default: w = 32'h5BE0CD19;
      endcase
      return w;
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] w, input logic [4:0] n);
      return (w >> n) | (w << (6'd32 - {1'b0, n}));
   endfunction

endpackage

>>> rtl/core/b3h_ctrl.sv
module b3h_ctrl
   import b3h_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  b3h_status_type st,
   output b3h_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_WRITE  = 3'd1;
   localparam logic [2:0] S_LOAD   = 3'd2;
   localparam logic [2:0] S_RUN    = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;
   localparam logic [2:0] S_MERGE  = 3'd5;
   localparam logic [2:0] S_FOLD   = 3'd6;
   localparam logic [2:0] S_EMIT   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [1:0] kind_ff, kind_in;
   logic [4:0] cnt_ff, cnt_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      cmd.kind  = kind_ff;
      cmd.phase = cnt_ff[1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            if (st.rem_zero) begin
               if (st.eom) begin
                  kind_in  = KIND_FINAL;
                  state_in = S_LOAD;
               end else begin
                  state_in = S_IDLE;
               end
            end else if (st.buf_full) begin
               kind_in  = KIND_BLOCK;
               state_in = S_LOAD;
            end else begin
               cmd.write = 1'b1;
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            cnt_in   = '0;
            state_in = S_RUN;
         end
         S_RUN: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 5'd1;
            if (cnt_ff == LAST_STEP) state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            unique case (kind_ff)
               KIND_BLOCK:  state_in = st.chunk_done ? S_MERGE : S_WRITE;
               KIND_PARENT: state_in = S_MERGE;
               default:     state_in = S_FOLD;
            endcase
         end
         S_MERGE: begin
            if (st.total_even && !st.level_zero) begin
               cmd.pop  = 1'b1;
               kind_in  = KIND_PARENT;
               state_in = S_LOAD;
            end else begin
               cmd.push = 1'b1;
               state_in = S_WRITE;
            end
         end
         S_FOLD: begin
            if (!st.level_zero) begin
               cmd.pop  = 1'b1;
               kind_in  = KIND_FPARENT;
               state_in = S_LOAD;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!st.out_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= KIND_BLOCK;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

>>> rtl/core/b3h_datapath.sv
module b3h_datapath
   import b3h_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  b3h_req_type    req_payload,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output b3h_rsp_type    rsp_payload,
   input  b3h_cmd_type    cmd,
   output b3h_status_type st
);

   logic [31:0] v_ff [16], v_in [16];
   logic [31:0] m_ff [16], m_in [16];
   logic [31:0] cv_ff [8], cv_in [8];
   logic [31:0] r_ff [8], r_in [8];
   logic [31:0] dig_ff [8], dig_in [8];
   logic [7:0]  buf_ff [64], buf_in [64];
   logic [6:0]  fill_ff, fill_in;
   logic [3:0]  bd_ff, bd_in;
   logic [63:0] chunk_ff, chunk_in;
   logic [63:0] total_ff, total_in;
   logic [5:0]  level_ff, level_in;
   logic [63:0] data_ff, data_in;
   logic [3:0]  rem_ff, rem_in;
   logic        eom_ff, eom_in;
   logic        oval_ff, oval_in;
   logic [1:0]  ocnt_ff, ocnt_in;

   logic [255:0] stack_mem [STACK_DEPTH];
   logic [255:0] rd_ff;
   logic [255:0] push_word;

   logic [31:0] res [8];
   logic [6:0]  space;
   logic [3:0]  k;
   logic        push_ok;

   assign space   = 7'd64 - fill_ff;
   assign k       = (space < {3'b0, rem_ff}) ? space[3:0] : rem_ff;
   assign push_ok = (level_ff < 6'(STACK_DEPTH));

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         res[i] = v_ff[i] ^ v_ff[i + 8];
         push_word[32*i +: 32] = r_ff[i];
      end
   end

   assign st.rem_zero   = (rem_ff == 4'd0);
   assign st.eom        = eom_ff;
   assign st.buf_full   = (fill_ff == 7'd64);
   assign st.chunk_done = (bd_ff == 4'd15);
   assign st.total_even = !total_ff[0];
   assign st.level_zero = (level_ff == 6'd0);
   assign st.out_busy   = oval_ff;

   assign rsp_valid               = oval_ff;
   assign rsp_payload.digest_word = {dig_ff[{ocnt_ff, 1'b1}], dig_ff[{ocnt_ff, 1'b0}]};
   assign rsp_payload.digest_last = (ocnt_ff == 2'd3);

   always_comb begin
      logic [6:0]  idx;
      logic [1:0]  gb, gc, gd;
      logic [3:0]  ia, ib, ic, id;
      logic [31:0] a, b, c, d, x;
      logic [31:0] flags;
      logic [7:0]  byte_v;
      v_in     = v_ff;
      m_in     = m_ff;
      cv_in    = cv_ff;
      r_in     = r_ff;
      dig_in   = dig_ff;
      buf_in   = buf_ff;
      fill_in  = fill_ff;
      bd_in    = bd_ff;
      chunk_in = chunk_ff;
      total_in = total_ff;
      level_in = level_ff;
      data_in  = data_ff;
      rem_in   = rem_ff;
      eom_in   = eom_ff;
      oval_in  = oval_ff;
      ocnt_in  = ocnt_ff;
      flags    = '0;

      if (cmd.take) begin
         data_in = req_payload.data_word;
         rem_in  = (req_payload.byte_count > 4'd8) ? 4'd8 : req_payload.byte_count;
         eom_in  = req_payload.end_of_message;
      end

      if (cmd.write) begin
         for (int j = 0; j < 64; j++) begin
            idx = 7'(j) - fill_ff;
            if ((7'(j) >= fill_ff) && (idx < {3'b0, k}))
               buf_in[j] = data_ff[{idx[2:0], 3'b0} +: 8];
         end
         data_in = data_ff >> {k, 3'b0};
         rem_in  = rem_ff - k;
         fill_in = fill_ff + {3'b0, k};
      end

      if (cmd.load) begin
         if (cmd.kind == KIND_BLOCK || cmd.kind == KIND_FINAL) begin
            if (bd_ff == 4'd0) flags = flags | FLAG_START;
            if (cmd.kind == KIND_FINAL) begin
               flags = flags | FLAG_END;
               if (level_ff == 6'd0) flags = flags | FLAG_ROOT;
            end else if (bd_ff == 4'd15) begin
               flags = flags | FLAG_END;
            end
            for (int i = 0; i < 8; i++) v_in[i] = cv_ff[i];
            v_in[12] = chunk_ff[31:0];
            v_in[13] = chunk_ff[63:32];
            v_in[14] = (cmd.kind == KIND_FINAL) ? {25'b0, fill_ff} : 32'd64;
            v_in[15] = flags;
            for (int j = 0; j < 64; j++) begin
               byte_v = (7'(j) < fill_ff) ? buf_ff[j] : 8'd0;
               m_in[j / 4][8*(j % 4) +: 8] = byte_v;
            end
         end else begin
            flags = FLAG_PARENT;
            if (cmd.kind == KIND_FPARENT && level_ff == 6'd0) flags = flags | FLAG_ROOT;
            for (int i = 0; i < 8; i++) begin
               v_in[i]     = iv_word(3'(i));
               m_in[i]     = rd_ff[32*i +: 32];
               m_in[i + 8] = r_ff[i];
            end
            v_in[12] = '0;
            v_in[13] = '0;
            v_in[14] = 32'd64;
            v_in[15] = flags;
         end
         for (int i = 0; i < 4; i++) v_in[i + 8] = iv_word(3'(i));
      end

      if (cmd.step) begin
         for (int g = 0; g < 4; g++) begin
            gb = 2'(g) + (cmd.phase[1] ? 2'd1 : 2'd0);
            gc = 2'(g) + (cmd.phase[1] ? 2'd2 : 2'd0);
            gd = 2'(g) + (cmd.phase[1] ? 2'd3 : 2'd0);
            ia = {2'b00, 2'(g)};
            ib = {2'b01, gb};
            ic = {2'b10, gc};
            id = {2'b11, gd};
            x  = m_ff[{cmd.phase[1], 2'(g), cmd.phase[0]}];
            a  = v_ff[ia];
            b  = v_ff[ib];
            c  = v_ff[ic];
            d  = v_ff[id];
            a  = a + b + x;
            d  = rotr(d ^ a, cmd.phase[0] ? 5'd8 : 5'd16);
            c  = c + d;
            b  = rotr(b ^ c, cmd.phase[0] ? 5'd7 : 5'd12);
            v_in[ia] = a;
            v_in[ib] = b;
            v_in[ic] = c;
            v_in[id] = d;
         end
         if (cmd.phase == 2'd3)
            for (int i = 0; i < 16; i++) m_in[i] = m_ff[PERM[i]];
      end

      if (cmd.finish) begin
         r_in = res;
         case (cmd.kind)
            KIND_BLOCK: begin
               fill_in = '0;
               if (bd_ff == 4'd15) begin
                  for (int i = 0; i < 8; i++) cv_in[i] = iv_word(3'(i));
                  bd_in    = '0;
                  chunk_in = chunk_ff + 64'd1;
                  total_in = chunk_ff + 64'd1;
               end else begin
                  cv_in = res;
                  bd_in = bd_ff + 4'd1;
               end
            end
            KIND_PARENT: total_in = total_ff >> 1;
            default: ;
         endcase
      end

      if (cmd.pop) level_in = level_ff - 6'd1;
      if (cmd.push && push_ok) level_in = level_ff + 6'd1;

      if (oval_ff && rsp_ready) begin
         ocnt_in = ocnt_ff + 2'd1;
         if (ocnt_ff == 2'd3) oval_in = 1'b0;
      end

      if (cmd.emit) begin
         dig_in  = r_ff;
         oval_in = 1'b1;
         ocnt_in = '0;
         for (int i = 0; i < 8; i++) cv_in[i] = iv_word(3'(i));
         fill_in  = '0;
         bd_in    = '0;
         chunk_in = '0;
         level_in = '0;
      end
   end

   // subtree stack
   always_ff @(posedge clock) begin
      if (cmd.push && push_ok) stack_mem[level_ff] <= push_word;
      if (cmd.pop) rd_ff <= stack_mem[level_ff - 6'd1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) cv_ff[i] <= iv_word(3'(i));
         fill_ff  <= '0;
         bd_ff    <= '0;
         chunk_ff <= '0;
         level_ff <= '0;
         rem_ff   <= '0;
         eom_ff   <= 1'b0;
         oval_ff  <= 1'b0;
         ocnt_ff  <= '0;
      end else begin
         cv_ff    <= cv_in;
         fill_ff  <= fill_in;
         bd_ff    <= bd_in;
         chunk_ff <= chunk_in;
         level_ff <= level_in;
         rem_ff   <= rem_in;
         eom_ff   <= eom_in;
         oval_ff  <= oval_in;
         ocnt_ff  <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff     <= v_in;
      m_ff     <= m_in;
      r_ff     <= r_in;
      dig_ff   <= dig_in;
      buf_ff   <= buf_in;
      total_ff <= total_in;
      data_ff  <= data_in;
   end

endmodule

>>> rtl/core/blake3_hash_256_unit.sv
// BLAKE3 hash, unkeyed, 256-bit digest.
// req_ channel: one word carries up to eight message bytes (byte 0 in bits 7:0),
//   a byte count (above eight reads as eight) and an end-of-message flag.
// rsp_ channel: after the end-of-message word, four digest words, bytes 0-7
//   first; digest_last marks the fourth.
// A word that fits the 64-byte block buffer passes through accept, byte write
//   and end check; a word with no bytes through accept and end check. A full
//   block is compressed when further bytes arrive: load, 28 quarter-round
//   steps of one shared G-lane array, finish. Each closed 1024-byte chunk
//   then costs one parent compression (stack read included) per merge, plus
//   a push. End of message: the last block is compressed, then one parent
//   compression per stacked subtree, then a hand-over, then the digest words
//   at one per cycle while the receiver is ready.
// The digest sits in an output register: the core returns to idle and takes
//   the next message while the receiver stalls, holding off only if a
//   second digest is ready before the first has drained.
// Reset (synchronous): chaining value to the IV, all counters and the stack
//   level cleared, no digest pending. Stack memory needs no clearing.
module blake3_hash_256_unit
   import b3h_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  b3h_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output b3h_rsp_type rsp_payload
);

   b3h_cmd_type    cmd;
   b3h_status_type st;

   b3h_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   b3h_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .st          (st)
   );

   // a new digest never overwrites one still draining
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !st.out_busy)
      else $error("digest emitted while output busy");

   // last word taken leaves the output empty
   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_payload.digest_last |=> !rsp_valid)
      else $error("output still valid after last digest word");

   // at most one datapath operation per cycle
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.take, cmd.write, cmd.load, cmd.step, cmd.finish,
                cmd.pop, cmd.push, cmd.emit}))
      else $error("conflicting datapath commands");

   // never pop an empty stack
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !st.level_zero)
      else $error("pop from empty subtree stack");

endmodule

>>> verif/testbench.sv
module testbench;
   import b3h_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RUN_LIMIT = 400000;   // cycles; far above the slowest correct run
   localparam int SETTLE    = 80;       // quiet cycles before a held-off word goes out

   localparam logic [3:0] WORD_ORDER [16] = '{
      4'd2, 4'd6, 4'd3, 4'd10, 4'd7, 4'd0, 4'd4, 4'd13,
      4'd1, 4'd11, 4'd12, 4'd5, 4'd9, 4'd14, 4'd15, 4'd8
   };

   localparam logic [255:0] IV = {
      32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
      32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
   };

   typedef struct {
      b3h_req_type word;
      bit          hold;     // wait for the pipe to drain first
      int          tx_pct;   // sender idle chance from this word on
      int          rx_pct;   // receiver stall chance from this word on
   } stim_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   b3h_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   b3h_rsp_type rsp_payload;

   stim_word_type pending_words [$];
   b3h_rsp_type   digest_queue [$];
   int          errors = 0;
   int          cycles = 0;
   int          quiet_cycles = 0;
   int          tx_pct = 0;
   int          rx_pct = 0;
   int          phase_tx = 0;
   int          phase_rx = 0;

   // hash state mirror
   logic [255:0] chain_cv;
   logic [511:0] blk_bytes;
   int           blk_fill;
   int           blk_done;
   logic [63:0]  chunk_ctr;
   logic [255:0] subtrees [STACK_DEPTH];
   int           level;

   blake3_hash_256_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // ------------------------------------------------------------------
   // Hash arithmetic
   // ------------------------------------------------------------------
   function automatic logic [31:0] ror32(input logic [31:0] w, input int n);
      return (w >> n) | (w << (32 - n));
   endfunction

   // one G mix; returns {a, b, c, d}
   function automatic logic [127:0] gmix(input logic [31:0] a, b, c, d, x, y);
      a = a + b + x;  d = ror32(d ^ a, 16);
      c = c + d;      b = ror32(b ^ c, 12);
      a = a + b + y;  d = ror32(d ^ a, 8);
      c = c + d;      b = ror32(b ^ c, 7);
      return {a, b, c, d};
   endfunction

   function automatic logic [255:0] compress_cv(input logic [255:0] cv,
                                                input logic [511:0] msg,
                                                input logic [31:0] len,
                                                input logic [63:0] ctr,
                                                input logic [31:0] flags);
      logic [31:0]  s [16];
      logic [31:0]  m [16];
      logic [31:0]  t [16];
      logic [255:0] res;
      for (int i = 0; i < 8; i++) begin
         s[i]     = cv[32*i +: 32];
         s[i + 8] = IV[32*(i % 4) +: 32];
      end
      s[12] = ctr[31:0];
      s[13] = ctr[63:32];
      s[14] = len;
      s[15] = flags;
      for (int i = 0; i < 16; i++) m[i] = msg[32*i +: 32];
      for (int r = 0; r < 7; r++) begin
         {s[0], s[4], s[8],  s[12]} = gmix(s[0], s[4], s[8],  s[12], m[0],  m[1]);
         {s[1], s[5], s[9],  s[13]} = gmix(s[1], s[5], s[9],  s[13], m[2],  m[3]);
         {s[2], s[6], s[10], s[14]} = gmix(s[2], s[6], s[10], s[14], m[4],  m[5]);
         {s[3], s[7], s[11], s[15]} = gmix(s[3], s[7], s[11], s[15], m[6],  m[7]);
         {s[0], s[5], s[10], s[15]} = gmix(s[0], s[5], s[10], s[15], m[8],  m[9]);
         {s[1], s[6], s[11], s[12]} = gmix(s[1], s[6], s[11], s[12], m[10], m[11]);
         {s[2], s[7], s[8],  s[13]} = gmix(s[2], s[7], s[8],  s[13], m[12], m[13]);
         {s[3], s[4], s[9],  s[14]} = gmix(s[3], s[4], s[9],  s[14], m[14], m[15]);
         for (int i = 0; i < 16; i++) t[i] = m[WORD_ORDER[i]];
         for (int i = 0; i < 16; i++) m[i] = t[i];
      end
      for (int i = 0; i < 8; i++) res[32*i +: 32] = s[i] ^ s[i + 8];
      return res;
   endfunction

   function automatic logic [255:0] merge_pair(input logic [255:0] left, right,
                                               input logic [31:0] flags);
      return compress_cv(IV, {right, left}, 32'd64, 64'd0, flags | FLAG_PARENT);
   endfunction

   // buffered bytes below the fill level, zeros above
   function automatic logic [511:0] filled_block();
      logic [511:0] msg;
      msg = '0;
      for (int i = 0; i < 64; i++)
         if (i < blk_fill) msg[8*i +: 8] = blk_bytes[8*i +: 8];
      return msg;
   endfunction

   function automatic void hash_clear();
      chain_cv  = IV;
      blk_fill  = 0;
      blk_done  = 0;
      chunk_ctr = '0;
      level     = 0;
   endfunction

   // full block with more bytes behind it; closes the chunk after sixteen
   function automatic void close_block();
      logic [31:0]  flags;
      logic [255:0] cv;
      logic [63:0]  total;
      flags = '0;
      if (blk_done == 0)  flags |= FLAG_START;
      if (blk_done == 15) flags |= FLAG_END;
      chain_cv = compress_cv(chain_cv, filled_block(), 32'd64, chunk_ctr, flags);
      blk_fill = 0;
      blk_done = (blk_done + 1) % 32;
      if (blk_done < 16) return;
      cv        = chain_cv;
      chain_cv  = IV;
      blk_done  = 0;
      chunk_ctr = chunk_ctr + 1;
      total     = chunk_ctr;
      for (int g = 0; g < 64 && total[0] == 1'b0 && level > 0; g++) begin
         level--;
         cv    = merge_pair(subtrees[level], cv, '0);
         total = total >> 1;
      end
      if (level < STACK_DEPTH) begin
         subtrees[level] = cv;
         level++;
      end
   endfunction

   // absorb one accepted word; queues the digest on end of message
   function automatic void absorb_word(input b3h_req_type w);
      int           count;
      logic [31:0]  flags;
      logic [255:0] cv;
      b3h_rsp_type  d;
      count = (w.byte_count > 4'd8) ? 8 : int'(w.byte_count);
      for (int i = 0; i < count; i++) begin
         if (blk_fill >= 64) close_block();
         blk_bytes[8*blk_fill +: 8] = w.data_word[8*i +: 8];
         blk_fill++;
      end
      if (!w.end_of_message) return;
      flags = FLAG_END;
      if (blk_done == 0) flags |= FLAG_START;
      if (level == 0)    flags |= FLAG_ROOT;
      cv = compress_cv(chain_cv, filled_block(), blk_fill, chunk_ctr, flags);
      while (level > 0) begin
         level--;
         cv = merge_pair(subtrees[level], cv, (level == 0) ? FLAG_ROOT : '0);
      end
      for (int i = 0; i < 4; i++) begin
         d.digest_word = cv[64*i +: 64];
         d.digest_last = (i == 3);
         digest_queue.push_back(d);
      end
      hash_clear();
   endfunction

   // ------------------------------------------------------------------
   // Stimulus building
   // ------------------------------------------------------------------
   function automatic void add_word(input logic [63:0] data, input int count,
                                    input bit eom, input bit hold);
      stim_word_type s;
      s.word.data_word      = data;
      s.word.byte_count     = count[3:0];
      s.word.end_of_message = eom;
      s.hold   = hold;
      s.tx_pct = phase_tx;
      s.rx_pct = phase_rx;
      pending_words.push_back(s);
   endfunction

   function automatic logic [63:0] rand_data();
      return {$urandom(), $urandom()};
   endfunction

   // random byte count: mostly 1..8, some empty noise, some oversized
   function automatic int rand_count();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 8)  return 0;
      if (pick < 16) return $urandom_range(9, 15);
      return $urandom_range(1, 8);
   endfunction

   // message of n body words; full = all body words carry eight bytes
   function automatic void add_message(input int n, input bit full, input bit hold);
      for (int i = 0; i < n; i++)
         add_word(rand_data(), full ? 8 : rand_count(), 1'b0, hold && i == 0);
      add_word(rand_data(), $urandom_range(0, 8), 1'b1, hold && n == 0);
   endfunction

   // ------------------------------------------------------------------
   // Clock, reset, run limit
   // ------------------------------------------------------------------
   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > RUN_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Driver: sender side. Valid holds until taken.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_words.size() > 0 &&
             !(pending_words[0].hold &&
               (digest_queue.size() != 0 || quiet_cycles < SETTLE)) &&
             $urandom_range(0, 99) >= tx_pct) begin
            req_valid   <= 1'b1;
            req_payload <= pending_words[0].word;
            tx_pct      <= pending_words[0].tx_pct;
            rx_pct      <= pending_words[0].rx_pct;
            void'(pending_words.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // quiet time since the last digest word drained or request word was taken
   always @(posedge clock) begin
      if (digest_queue.size() != 0 || (req_valid && req_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   // predict on every accepted word
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) absorb_word(req_payload);
   end

   // receiver side stalls
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(0, 99) >= rx_pct);
   end

   // ------------------------------------------------------------------
   // Monitor: each digest word against the oldest prediction
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      b3h_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (digest_queue.size() == 0) begin
            $display("%0t: unexpected digest word %h last %b", $time,
                     rsp_payload.digest_word, rsp_payload.digest_last);
            errors++;
         end else begin
            want = digest_queue.pop_front();
            if (rsp_payload.digest_word !== want.digest_word) begin
               $display("%0t: digest_word expected %h actual %h", $time,
                        want.digest_word, rsp_payload.digest_word);
               errors++;
            end
            if (rsp_payload.digest_last !== want.digest_last) begin
               $display("%0t: digest_last expected %b actual %b", $time,
                        want.digest_last, rsp_payload.digest_last);
               errors++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequence: directed words, then random messages in idling phases
   // ------------------------------------------------------------------
   initial begin
      int msg_no;
      hash_clear();
      blk_bytes = '0;

      // directed, no idling
      add_word(rand_data(), 0, 1'b1, 1'b0);                // empty message
      add_word({64{1'b1}}, 1, 1'b1, 1'b0);                 // single byte
      add_word('0, 8, 1'b0, 1'b0);                         // zero bytes then ones
      add_word({64{1'b1}}, 8, 1'b1, 1'b0);
      add_word(rand_data(), 15, 1'b1, 1'b0);               // oversized count
      add_word(rand_data(), 0, 1'b0, 1'b0);                // empty word, no end
      add_word(rand_data(), 9, 1'b0, 1'b0);
      add_word(rand_data(), 3, 1'b1, 1'b0);
      for (int i = 0; i < 8; i++)                          // exactly one block
         add_word(rand_data(), 8, 1'b0, 1'b0);
      add_word(rand_data(), 0, 1'b1, 1'b0);
      for (int i = 0; i < 8; i++)                          // block plus one byte
         add_word(rand_data(), 8, 1'b0, 1'b0);
      add_word(rand_data(), 1, 1'b1, 1'b0);

      // one full chunk and up to eight more bytes, closed lazily; with drain hold-off
      phase_tx = 0;  phase_rx = 0;
      add_message(128, 1'b1, 1'b1);
      // two chunks and a bit: a parent merge and a root fold
      phase_tx = 18; phase_rx = 18;
      add_message(260, 1'b1, 1'b0);

      msg_no = 0;
      while (pending_words.size() < 500) begin
         case (msg_no % 4)
            0: begin phase_tx = 0;  phase_rx = 0;  end
            1: begin phase_tx = 71; phase_rx = 0;  end
            2: begin phase_tx = 0;  phase_rx = 71; end
            default: begin phase_tx = 18; phase_rx = 18; end
         endcase
         add_message($urandom_range(0, 20), 1'b0, (msg_no % 9) == 4);
         msg_no++;
      end

      @(negedge reset);
      do @(posedge clock);
      while (pending_words.size() != 0 || req_valid || digest_queue.size() != 0);
      repeat (200) @(posedge clock);

      if (errors == 0 && digest_queue.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
